FILE: rtl/core/uigf_pkg.sv
// Package for the idle-gap UART frame receiver.
// Holds the operation and result codes, field widths, reset constants and shared types.
// No dependencies; every other file of the block imports it.
package uigf_pkg;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int TIME_W = 8;
    localparam int LEN_W  = 7;
    localparam int KIND_W = 2;

    localparam logic [OP_W-1:0] OP_RX   = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    localparam logic [TIME_W-1:0] IDLE_LIMIT_RST = 8'd30;
    localparam logic [TIME_W-1:0] TIMER_MAX      = 8'd255;
    localparam int                MAX_RESULTS    = 64;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic busy;
        logic frame_ready;
    } t_status;

endpackage

FILE: rtl/core/uigf_if.sv
// Channel interfaces of the idle-gap UART frame receiver: input items and result beats.
// Depends on uigf_pkg for field widths.
interface uigf_in_if;
    import uigf_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] rx_byte;
    logic [TIME_W-1:0] tick_ms;
    logic [LEN_W-1:0]  read_max;

    modport source (output valid, opcode, rx_byte, tick_ms, read_max, input ready);
    modport sink   (input valid, opcode, rx_byte, tick_ms, read_max, output ready);
endinterface

interface uigf_out_if;
    import uigf_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    logic [LEN_W-1:0]  frame_length;

    modport source (output valid, result_kind, data_byte, last, frame_length, input ready);
    modport sink   (input valid, result_kind, data_byte, last, frame_length, output ready);
endinterface

FILE: rtl/core/uigf_store.sv
// Byte store of the frame receiver: one write port, one registered read port.
// Depends on uigf_pkg for the byte width.
module uigf_store #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [uigf_pkg::BYTE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [uigf_pkg::BYTE_W-1:0] o_rdata
);
    import uigf_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/uigf_ctrl.sv
// Control of the frame receiver: item decode, idle timer, read sequencer, result register.
// Depends on uigf_pkg and the channel interfaces in uigf_if.sv.
module uigf_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [uigf_pkg::TIME_W-1:0] i_idle_limit,
    uigf_in_if.sink                     i_item,
    uigf_out_if.source                  o_result,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [uigf_pkg::BYTE_W-1:0] o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [uigf_pkg::BYTE_W-1:0] i_mem_rdata,
    output uigf_pkg::t_status           o_status
);
    import uigf_pkg::*;

    localparam int XW = (CW > LEN_W) ? CW : LEN_W;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_count_tick;
    logic [TIME_W-1:0]  r_idle;
    logic               r_frame_ready;
    logic [LEN_W-1:0]   r_n;
    logic [LEN_W-1:0]   r_issue;
    logic [LEN_W-1:0]   r_sent;
    logic               r_pend;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic [BYTE_W-1:0]  r_out_data;
    logic               r_out_last;
    logic [LEN_W-1:0]   r_out_len;

    logic               out_free;
    logic               in_ready;
    logic               accept;
    logic               issue;
    logic               load;
    logic               last_beat;
    logic [LEN_W-1:0]   sent_inc;
    logic [LEN_W-1:0]   rd_n;
    logic [XW-1:0]      held_x;
    logic [XW-1:0]      lim_x;
    logic [XW-1:0]      rmax_x;
    logic [TIME_W:0]    tick_sum;
    logic [TIME_W-1:0]  tick_sat;
    logic [LEN_W-1:0]   cur_len;

    assign out_free = !r_out_valid || o_result.ready;
    assign accept   = i_item.valid && in_ready;
    assign sent_inc = r_sent + LEN_W'(1);
    assign last_beat = (sent_inc == r_n);
    assign cur_len  = LEN_W'(r_count);

    // clamp the read to what is held and to the result limit
    assign held_x = XW'(r_count);
    assign lim_x  = (held_x > XW'(MAX_RESULTS)) ? XW'(MAX_RESULTS) : held_x;
    assign rmax_x = XW'(i_item.read_max);
    assign rd_n   = LEN_W'((rmax_x < lim_x) ? rmax_x : lim_x);

    assign tick_sum = {1'b0, r_idle} + {1'b0, i_item.tick_ms};
    assign tick_sat = tick_sum[TIME_W] ? TIMER_MAX : tick_sum[TIME_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_item.opcode == OP_READ && rd_n != '0) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (load && last_beat) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ready = out_free;
            end
            S_READ: begin
                load  = r_pend && out_free;
                issue = (r_issue != r_n) && (!r_pend || load);
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign i_item.ready = in_ready;

    // appends only happen while idle, reads only while streaming: no overlap on an entry
    assign o_mem_we    = accept && i_item.opcode == OP_RX && r_count < CW'(DEPTH);
    assign o_mem_waddr = AW'(r_count);
    assign o_mem_wdata = i_item.rx_byte;
    assign o_mem_re    = issue;
    assign o_mem_raddr = AW'(r_issue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_count_tick  <= '0;
            r_idle        <= '0;
            r_frame_ready <= 1'b0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_n           <= '0;
            r_issue       <= '0;
            r_sent        <= '0;
        end else begin
            r_state <= n_state;
            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                case (i_item.opcode)
                    OP_RX: begin
                        if (o_mem_we) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    OP_TICK: begin
                        if (r_count == '0) begin
                            r_count_tick <= '0;
                        end else if (r_count_tick != r_count) begin
                            r_count_tick <= r_count;
                            r_idle       <= '0;
                        end else if (r_idle < i_idle_limit) begin
                            r_idle <= tick_sat;
                            if (tick_sat >= i_idle_limit) begin
                                r_frame_ready <= 1'b1;
                                r_out_valid   <= 1'b1;
                            end
                        end
                    end
                    OP_READ: begin
                        r_n     <= rd_n;
                        r_issue <= '0;
                        r_sent  <= '0;
                        r_pend  <= 1'b0;
                        if (rd_n == '0) begin
                            r_out_valid   <= 1'b1;
                            r_count       <= '0;
                            r_frame_ready <= 1'b0;
                        end
                    end
                    default: begin
                        r_out_valid <= r_out_valid && !o_result.ready;
                    end
                endcase
            end
            if (issue) begin
                r_issue <= r_issue + LEN_W'(1);
            end
            if (issue) begin
                r_pend <= 1'b1;
            end else if (load) begin
                r_pend <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
                r_sent      <= sent_inc;
                if (last_beat) begin
                    r_count       <= '0;
                    r_frame_ready <= 1'b0;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept && i_item.opcode == OP_TICK) begin
            r_out_kind <= KIND_DONE;
            r_out_data <= '0;
            r_out_last <= 1'b1;
            r_out_len  <= cur_len;
        end else if (accept && i_item.opcode == OP_READ) begin
            r_out_kind <= KIND_EMPTY;
            r_out_data <= '0;
            r_out_last <= 1'b1;
            r_out_len  <= cur_len;
        end else if (load) begin
            r_out_kind <= KIND_DATA;
            r_out_data <= i_mem_rdata;
            r_out_last <= last_beat;
            r_out_len  <= cur_len;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.result_kind  = r_out_kind;
    assign o_result.data_byte    = r_out_data;
    assign o_result.last         = r_out_last;
    assign o_result.frame_length = r_out_len;

    assign o_status.busy        = (r_state == S_READ);
    assign o_status.frame_ready = r_frame_ready;

endmodule

FILE: rtl/core/uart_idle_gap_frame_receiver_core.sv
// Idle-gap UART frame receiver. Received bytes (opcode 0) append to a store of STORE_DEPTH
// bytes and are dropped once it is full. Timer ticks (opcode 1) run an idle timer that
// restarts whenever the byte count grew since the previous tick and otherwise adds tick_ms,
// saturating at 255; the first time it reaches idle_limit a frame-complete beat carrying the
// frame length goes out. A read request (opcode 2) streams out the held bytes, at most
// read_max and at most 64, with last set on the final beat, or a single empty-read beat,
// and then clears the count and the frame flag. Opcode 3 is ignored. The input side stays
// closed while a read streams; the store's single registered read port then delivers
// one byte per cycle when the output does not stall. The store needs no clearing pass
// after reset; only bytes written since the last read are ever read back. idle_limit is
// written through i_cfg_we / i_cfg_wdata and resets to 30; it is to be written only while
// the block is idle, a rule for the user that the block itself does not enforce.
module uart_idle_gap_frame_receiver_core #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [uigf_pkg::TIME_W-1:0] i_cfg_wdata,
    uigf_in_if.sink                     i_item,
    uigf_out_if.source                  o_result
);
    import uigf_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    logic [TIME_W-1:0] r_idle_limit;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;
    t_status           status;

    // idle limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= IDLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_idle_limit <= i_cfg_wdata;
        end
    end

    uigf_ctrl #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_idle_limit (r_idle_limit),
        .i_item       (i_item),
        .o_result     (o_result),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_status     (status)
    );

    uigf_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // no new item while a read is streaming
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.busy |-> !i_item.ready)
        else $error("input accepted during a read");

    // the end of a read leaves the frame flag clear
    a_read_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(status.busy) |-> !status.frame_ready)
        else $error("frame flag still set after read");

    // a final data beat is only shown once the sequencer has finished
    a_last_data_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.result_kind == KIND_DATA && o_result.last)
            |-> !status.busy)
        else $error("last data beat while read still running");

endmodule

FILE: bench/uigf_tb_pkg.sv
`timescale 1ns / 1ps
// Frame tracker for the idle-gap UART frame receiver bench: predicts result beats.
// Depends on uigf_pkg for codes and widths.
package uigf_tb_pkg;
    import uigf_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [LEN_W-1:0]  len;
    } t_frame_beat;

    class frame_tracker;
        int unsigned       depth;
        logic [BYTE_W-1:0] held_bytes[];
        logic [LEN_W-1:0]  held;
        logic [LEN_W-1:0]  held_at_tick;
        logic [TIME_W-1:0] idle_ms;
        logic [TIME_W-1:0] limit_ms;
        logic              frame_flag;
        t_frame_beat       expected_beats[$];
        int unsigned       errors;
        int unsigned       beats_checked;
        int unsigned       notices;
        int unsigned       reads;
        int unsigned       dropped;

        function new(int unsigned store_depth);
            depth         = store_depth;
            held_bytes    = new[store_depth];
            held          = '0;
            held_at_tick  = '0;
            idle_ms       = '0;
            limit_ms      = IDLE_LIMIT_RST;
            frame_flag    = 1'b0;
            errors        = 0;
            beats_checked = 0;
            notices       = 0;
            reads         = 0;
            dropped       = 0;
        endfunction

        function void set_limit(logic [TIME_W-1:0] value);
            limit_ms = value;
        endfunction

        function bit drained();
            return expected_beats.size() == 0;
        endfunction

        function void push_beat(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                logic last, logic [LEN_W-1:0] len);
            t_frame_beat b;
            b.kind = kind;
            b.data = data;
            b.last = last;
            b.len  = len;
            expected_beats.push_back(b);
        endfunction

        // Advance the predicted state by one accepted input beat.
        function void note_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] rx,
                                logic [TIME_W-1:0] ms, logic [LEN_W-1:0] rmax);
            logic [TIME_W:0] sum;
            int unsigned     n;
            case (op)
                OP_RX: begin
                    if (held < depth) begin
                        held_bytes[held] = rx;
                        held++;
                    end else begin
                        dropped++;
                    end
                end
                OP_TICK: begin
                    if (held == 0) begin
                        held_at_tick = '0;
                    end else if (held_at_tick != held) begin
                        held_at_tick = held;
                        idle_ms = '0;
                    end else if (idle_ms < limit_ms) begin
                        sum = idle_ms + ms;
                        idle_ms = (sum > TIMER_MAX) ? TIMER_MAX : sum[TIME_W-1:0];
                        if (idle_ms >= limit_ms) begin
                            frame_flag = 1'b1;
                            notices++;
                            push_beat(KIND_DONE, '0, 1'b1, held);
                        end
                    end
                end
                OP_READ: begin
                    n = rmax;
                    if (n > held) n = held;
                    if (n > MAX_RESULTS) n = MAX_RESULTS;
                    if (n == 0) push_beat(KIND_EMPTY, '0, 1'b1, held);
                    for (int i = 0; i < n; i++)
                        push_beat(KIND_DATA, held_bytes[i], (i + 1 == n), held);
                    held = '0;
                    frame_flag = 1'b0;
                    reads++;
                end
                default: ;
            endcase
        endfunction

        function void report(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        endfunction

        // Compare one accepted result beat with the oldest prediction.
        function void check_beat(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                 logic last, logic [LEN_W-1:0] len);
            t_frame_beat want;
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none actual kind %0h data %0h",
                         $time, kind, data);
                return;
            end
            want = expected_beats.pop_front();
            beats_checked++;
            if (kind !== want.kind) report("result_kind", want.kind, kind);
            if (data !== want.data) report("data_byte", want.data, data);
            if (last !== want.last) report("last", want.last, last);
            if (len !== want.len) report("frame_length", want.len, len);
        endfunction
    endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Top-level bench for uart_idle_gap_frame_receiver_core: directed, pressure and random phases.
// Depends on uigf_pkg, the channel interfaces and the frame tracker in uigf_tb_pkg.
module tb_top;
    import uigf_pkg::*;
    import uigf_tb_pkg::*;

    localparam int      DEPTH       = 64;
    localparam int      CLK_HALF    = 2;
    localparam longint  CYCLE_LIMIT = 6_000_000;
    localparam int      PHASE_ITEMS = 70;
    localparam int      HOLD_CYCLES = 400;
    localparam int      SETTLE      = 16;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [TIME_W-1:0] cfg_wdata;

    uigf_in_if  item_if ();
    uigf_out_if res_if ();

    frame_tracker sb;
    longint       cycles     = 0;
    int           items_sent = 0;
    int           stall_left = 0;
    int           run_left   = 0;
    bit           calm       = 1'b0;   // no idling on either side while set
    bit           hold_req   = 1'b0;   // ask the receiver for one long hold-off

    uart_idle_gap_frame_receiver_core #(
        .STORE_DEPTH (DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_if),
        .o_result    (res_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog: stop a hung run well beyond the slowest legal schedule.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycles, sb.expected_beats.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Sample both handshakes at the edge. Note the input beat before checking the
    // output beat so ordering inside the time step never matters.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (item_if.valid && item_if.ready)
                sb.note_item(item_if.opcode, item_if.rx_byte, item_if.tick_ms,
                             item_if.read_max);
            if (res_if.valid && res_if.ready)
                sb.check_beat(res_if.result_kind, res_if.data_byte, res_if.last,
                              res_if.frame_length);
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [TIME_W-1:0] tick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return TIME_W'($urandom_range(0, 40));
        if (r < 80) return TIME_W'($urandom_range(0, 255));
        return TIMER_MAX;
    endfunction

    function automatic logic [LEN_W-1:0] read_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return LEN_W'(MAX_RESULTS);
        if (r < 55) return '0;
        return LEN_W'($urandom_range(0, MAX_RESULTS));
    endfunction

    // Result side: drive ready with random stalls; a hold-off request closes it
    // for one long stretch.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (calm || run_left > 0) begin
                if (run_left > 0) run_left--;
                res_if.ready <= 1'b1;
            end else begin
                run_left   = $urandom_range(1, 30);
                stall_left = gap_len();
                res_if.ready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Present one beat and hold it until accepted. Valid stays high on return so a
    // back-to-back beat never lowers and raises it in the same step.
    task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] rx,
                             logic [TIME_W-1:0] ms, logic [LEN_W-1:0] rmax);
        item_if.valid    <= 1'b1;
        item_if.opcode   <= op;
        item_if.rx_byte  <= rx;
        item_if.tick_ms  <= ms;
        item_if.read_max <= rmax;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        if (op != OP_IGNORED) items_sent++;
    endtask

    // Idle the input for a random gap, then send one beat.
    task automatic offer(logic [OP_W-1:0] op, logic [BYTE_W-1:0] rx,
                         logic [TIME_W-1:0] ms, logic [LEN_W-1:0] rmax);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        send_item(op, rx, ms, rmax);
    endtask

    // Drop valid and hold until every predicted beat has come back, then let
    // the block settle. The first edge lets the monitor note the last input.
    task automatic wait_drain();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (!sb.drained());
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [TIME_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_limit(value);
    endtask

    // Well-formed frame: a burst of bytes, a few ticks to close it, usually a read.
    task automatic frame_seq();
        int r;
        int nb;
        int nt;
        r  = $urandom_range(0, 99);
        nb = (r < 70) ? $urandom_range(1, 10) :
             (r < 92) ? $urandom_range(11, 40) : $urandom_range(41, 70);
        for (int k = 0; k < nb; k++) begin
            if ($urandom_range(0, 19) == 0)
                offer(OP_TICK, BYTE_W'($urandom), tick_len(),
                      LEN_W'($urandom_range(0, 64)));
            offer(OP_RX, BYTE_W'($urandom), TIME_W'($urandom),
                  LEN_W'($urandom_range(0, 64)));
        end
        nt = $urandom_range(1, 5);
        for (int k = 0; k < nt; k++)
            offer(OP_TICK, BYTE_W'($urandom), tick_len(), LEN_W'($urandom_range(0, 64)));
        if ($urandom_range(0, 9) < 8)
            offer(OP_READ, BYTE_W'($urandom), TIME_W'($urandom), read_len());
    endtask

    // Noise: a few beats of any opcode, the ignored one included.
    task automatic noise_seq();
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
            offer(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom), tick_len(), read_len());
    endtask

    initial begin
        logic [TIME_W-1:0] lim;
        int                goal;
        sb = new(DEPTH);
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        item_if.valid    <= 1'b0;
        item_if.opcode   <= OP_RX;
        item_if.rx_byte  <= '0;
        item_if.tick_ms  <= '0;
        item_if.read_max <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, idle limit at its reset value of 30.
        send_item(OP_READ, 8'hFF, 8'hFF, '0);          // empty read, nothing held
        send_item(OP_READ, 8'h00, 8'h00, 7'd64);       // empty read with largest request
        send_item(OP_TICK, 8'hFF, 8'hFF, 7'd64);       // tick on an empty store
        send_item(OP_IGNORED, 8'hFF, 8'hFF, 7'd64);    // ignored opcode
        send_item(OP_RX, 8'h00, 8'h00, '0);
        send_item(OP_RX, 8'hFF, 8'hFF, 7'd64);
        send_item(OP_RX, 8'hA5, 8'h00, '0);
        send_item(OP_TICK, 8'h00, 8'd0, '0);           // count grew: restart timer
        send_item(OP_TICK, 8'h00, 8'd29, '0);          // one short of the limit
        send_item(OP_TICK, 8'h00, 8'd1, '0);           // reaches it: frame notice
        send_item(OP_TICK, 8'h00, 8'd255, '0);         // already past: no second notice
        send_item(OP_READ, 8'h00, 8'h00, '0);          // zero request still clears
        send_item(OP_RX, 8'h5A, 8'h00, '0);
        send_item(OP_TICK, 8'h00, 8'd0, '0);           // count changed: restart timer
        send_item(OP_TICK, 8'h00, 8'd7, '0);
        send_item(OP_TICK, 8'h00, 8'd255, '0);         // saturating add
        send_item(OP_READ, 8'h00, 8'h00, 7'd64);       // request clamped to one held byte
        send_item(OP_RX, 8'h3C, 8'h00, '0);
        send_item(OP_RX, 8'hC3, 8'h00, '0);
        send_item(OP_READ, 8'h00, 8'h00, 7'd1);        // fewer requested than held
        send_item(OP_RX, 8'h81, 8'h00, '0);
        send_item(OP_TICK, 8'h00, 8'd0, '0);
        send_item(OP_READ, 8'h00, 8'h00, 7'd63);
        wait_drain();

        // Pressure: overfill the store, then stall the result side for a long
        // stretch while a full read and more beats are offered behind it.
        calm = 1'b1;
        for (int k = 0; k < DEPTH + 6; k++)
            send_item(OP_RX, BYTE_W'($urandom), TIME_W'($urandom),
                      LEN_W'($urandom_range(0, 64)));
        calm = 1'b0;
        hold_req = 1'b1;
        send_item(OP_READ, BYTE_W'($urandom), TIME_W'($urandom), 7'd64);
        for (int k = 0; k < 8; k++)
            send_item(OP_RX, BYTE_W'($urandom), TIME_W'($urandom),
                      LEN_W'($urandom_range(0, 64)));
        send_item(OP_TICK, BYTE_W'($urandom), 8'd0, LEN_W'($urandom_range(0, 64)));
        send_item(OP_TICK, BYTE_W'($urandom), 8'd255, LEN_W'($urandom_range(0, 64)));
        send_item(OP_READ, BYTE_W'($urandom), TIME_W'($urandom), 7'd64);
        wait_drain();

        // Random phases at the extreme limits and two random ones; the third
        // runs with no idling on either side.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       lim = 8'd1;
                1:       lim = TIMER_MAX;
                default: lim = TIME_W'($urandom_range(2, 254));
            endcase
            write_limit(lim);
            calm = (phase == 2);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                if ($urandom_range(0, 99) < 75) frame_seq();
                else noise_seq();
            end
            calm = 1'b0;
            wait_drain();
        end

        if (!sb.drained()) begin
            sb.errors++;
            $display("%0t: %0d predicted beats never arrived", $time, sb.expected_beats.size());
        end
        $display("covered %0d input beats under idle limits 30, 1, 255 and two random values",
                 items_sent);
        $display("%0d reads, %0d frame notices, %0d dropped bytes, %0d result beats checked",
                 sb.reads, sb.notices, sb.dropped, sb.beats_checked);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
